@@ hdl/krt_pkg.sv @@
package krt_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_UPDATE,
        KIND_REMOVE,
        KIND_NONE
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_MISSING,
        ST_FULL
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_SHIFT,
        S_REPLY
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] key;
        logic [15:0] quantity;
        logic [23:0] price;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [6:0]  entries_used;
        logic [5:0]  slot;
    } t_rsp;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] quantity;
        logic [23:0] price;
    } t_rec;

endpackage

@@ hdl/krt_ram.sv @@
module krt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/keyed_record_table.sv @@
// Channel   Direction  Signals                     Payload
// request   in         i_in_valid / o_in_stall     i_in  (krt_pkg::t_req)
// response  out        o_out_valid / i_out_stall   o_out (krt_pkg::t_rsp)
//
// Add and no-op requests pass through S_START and S_REPLY from accept to response valid.
// Update walks the table one entry per cycle until a hit or the end of the records.
// Remove walks the same way, then moves one entry per cycle above the hit down a slot;
// the single RAM port pair (one read, one write per cycle) sets the pace. A stalled
// response holds the block in S_REPLY until the output is free.
// Reset (i_rst_n low, synchronous) empties the table; record storage is not cleared.
// A new request is taken while a finished response is still stalled at the output.
module keyed_record_table #(
    parameter int unsigned TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  krt_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output krt_pkg::t_rsp o_out
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned RW = $bits(krt_pkg::t_rec);

    krt_pkg::t_state  r_state, n_state;
    krt_pkg::t_req    r_req, n_req;
    krt_pkg::t_status r_status, n_status;
    krt_pkg::t_rsp    r_out, n_out;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_cmp, n_cmp;
    logic [5:0]       r_slot, n_slot;
    logic             r_pend, n_pend;
    logic             r_out_valid, n_out_valid;

    logic             w_we;
    logic [AW-1:0]    w_wr_addr;
    logic [RW-1:0]    w_wr_data;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic [RW-1:0]    w_rd_data;
    krt_pkg::t_rec    w_rd_rec;
    logic             w_hit;
    logic             w_more;
    logic             w_out_free;

    krt_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_rec   = krt_pkg::t_rec'(w_rd_data);
    assign w_hit      = r_pend && (w_rd_rec.key == r_req.key);
    assign w_more     = r_ptr < r_count;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != krt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            krt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = krt_pkg::S_START;
                end
            end
            krt_pkg::S_START: begin
                case (r_req.kind)
                    krt_pkg::KIND_UPDATE, krt_pkg::KIND_REMOVE: n_state = krt_pkg::S_SEARCH;
                    default:                                    n_state = krt_pkg::S_REPLY;
                endcase
            end
            krt_pkg::S_SEARCH: begin
                if (w_hit) begin
                    n_state = (r_req.kind == krt_pkg::KIND_REMOVE) ? krt_pkg::S_SHIFT
                                                                   : krt_pkg::S_REPLY;
                end else if (!w_more) begin
                    n_state = krt_pkg::S_REPLY;
                end
            end
            krt_pkg::S_SHIFT: begin
                if (!w_more) begin
                    n_state = krt_pkg::S_REPLY;
                end
            end
            krt_pkg::S_REPLY: begin
                if (w_out_free) begin
                    n_state = krt_pkg::S_IDLE;
                end
            end
            default: n_state = krt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_status    = r_status;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_cmp       = r_cmp;
        n_slot      = r_slot;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_wr_addr   = r_cmp;
        w_wr_data   = {r_req.key, r_req.quantity, r_req.price};
        w_rd_en     = 1'b0;
        w_rd_addr   = r_ptr[AW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            krt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in;
                end
            end
            krt_pkg::S_START: begin
                n_status = krt_pkg::ST_DONE;
                n_slot   = '0;
                n_ptr    = '0;
                n_pend   = 1'b0;
                case (r_req.kind)
                    krt_pkg::KIND_ADD: begin
                        if (r_count >= CW'(TABLE_DEPTH)) begin
                            n_status = krt_pkg::ST_FULL;
                        end else begin
                            w_we      = 1'b1;
                            w_wr_addr = r_count[AW-1:0];
                            n_count   = r_count + CW'(1);
                            n_slot    = 6'(r_count);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            krt_pkg::S_SEARCH: begin
                if (w_hit) begin
                    n_pend = 1'b0;
                    n_slot = 6'(r_cmp);
                    if (r_req.kind == krt_pkg::KIND_REMOVE) begin
                        n_ptr = CW'(r_cmp) + CW'(1);
                    end else begin
                        w_we = 1'b1;
                    end
                end else if (w_more) begin
                    w_rd_en = 1'b1;
                    n_ptr   = r_ptr + CW'(1);
                    n_cmp   = r_ptr[AW-1:0];
                    n_pend  = 1'b1;
                end else begin
                    n_pend   = 1'b0;
                    n_status = krt_pkg::ST_MISSING;
                end
            end
            krt_pkg::S_SHIFT: begin
                if (r_pend) begin
                    w_we      = 1'b1;
                    w_wr_addr = r_cmp - AW'(1);
                    w_wr_data = w_rd_data;
                end
                n_pend = w_more;
                if (w_more) begin
                    w_rd_en = 1'b1;
                    n_ptr   = r_ptr + CW'(1);
                    n_cmp   = r_ptr[AW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            krt_pkg::S_REPLY: begin
                if (w_out_free) begin
                    n_out.status       = r_status;
                    n_out.entries_used = 7'(r_count);
                    n_out.slot         = r_slot;
                    n_out_valid        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= krt_pkg::S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_req    <= n_req;
        r_status <= n_status;
        r_ptr    <= n_ptr;
        r_cmp    <= n_cmp;
        r_slot   <= n_slot;
        r_out    <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("record count above table depth");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == krt_pkg::S_SEARCH || r_state == krt_pkg::S_SHIFT) |-> r_ptr <= r_count)
        else $error("walk pointer past record count");

    a_write_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_state != krt_pkg::S_START) |-> CW'(w_wr_addr) < r_count)
        else $error("record write outside filled range");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == krt_pkg::S_SHIFT && !w_more) |=> r_count == CW'($past(r_count) - CW'(1)))
        else $error("remove did not drop record count");

    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != krt_pkg::ST_DONE) |-> r_out.slot == 6'd0)
        else $error("failed request reports nonzero slot");

endmodule
